### rtl/lpl_pkg.sv
// ============================================================================
// lpl_pkg - shared types and constants of the lookahead peak limiter
// Fixed field widths, configuration register indexes, gain constants and
// the sequencer state encoding.
// ============================================================================
`default_nettype none

package lpl_pkg;

    // Fixed field widths
    localparam int FRAC_W    = 16;          // Q0.16 fraction bits
    localparam int GAIN_W    = 17;          // gain envelope, 65536 is unity
    localparam int CEIL_W    = 15;
    localparam int COEF_W    = 16;
    localparam int DELAY_W   = 8;
    localparam int CHAN_W    = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W     = 2 * FRAC_W + 1;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CEIL_W-1:0]  CEILING_RST = 15'd31655;
    localparam logic [COEF_W-1:0]  RELEASE_RST = 16'd65522;
    localparam logic [DELAY_W-1:0] DELAY_RST   = 8'd240;
    localparam logic [CHAN_W-1:0]  CHANNEL_RST = 2'd2;

    // Sequencer states
    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_DIV    = 10'b00_0000_0100,
        ST_MUL_CE = 10'b00_0000_1000,
        ST_MUL_CD = 10'b00_0001_0000,
        ST_ACC    = 10'b00_0010_0000,
        ST_ENV    = 10'b00_0100_0000,
        ST_MUL_L  = 10'b00_1000_0000,
        ST_MUL_R  = 10'b01_0000_0000,
        ST_FIN    = 10'b10_0000_0000
    } lpl_state_t;

endpackage

`default_nettype wire

### rtl/lpl_ram.sv
// ============================================================================
// lpl_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module lpl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/lpl_div.sv
// ============================================================================
// lpl_div - serial restoring divider for the wanted gain
// Computes floor(ceiling * 65536 / peak) for peak above ceiling, one
// quotient bit per cycle.
// ============================================================================
`default_nettype none

module lpl_div
    import lpl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [CEIL_W-1:0]       ceiling,
    input  wire logic [SAMPLE_WIDTH-1:0] peak,
    output logic                         done,
    output logic [FRAC_W-1:0]            quotient
);

    localparam int CNT_W = $clog2(FRAC_W);

    logic [SAMPLE_WIDTH-1:0] rem_reg, rem_next;
    logic [SAMPLE_WIDTH-1:0] dvs_reg, dvs_next;
    logic [FRAC_W-1:0]       q_reg, q_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [SAMPLE_WIDTH:0]   shifted;
    logic                    fits;

    // remainder stays below the divisor, so the shifted value needs one bit more
    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // ceiling is below peak here, so it fits the remainder
            rem_next  = SAMPLE_WIDTH'(ceiling);
            dvs_next  = peak;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = SAMPLE_WIDTH'(shifted - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = shifted[SAMPLE_WIDTH-1:0];
            end
            q_next   = {q_reg[FRAC_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

### rtl/lookahead_peak_limiter.sv
// ============================================================================
// lookahead_peak_limiter - lookahead brickwall limiter for stereo frames
// Peak detect, serial gain division, envelope smoothing and delayed gain
// application on one shared multiplier under a small sequencer.
// ============================================================================
// Usage:
//   Input channel: one stereo frame (left_sample, right_sample) is taken at a
//   clock edge with in_valid high and in_stall low. The block raises in_stall
//   while it works on a frame; it takes one frame at a time.
//   Output channel: left_out, right_out and gain_now form one item, taken at
//   an edge with out_valid high and out_stall low. The result sits in an
//   output register, so the next frame is accepted while it waits.
//   Sequence: a frame whose peak is at or below the ceiling goes straight to
//   the envelope steps; above the ceiling, the 16-step serial divider first
//   works out the wanted gain. The envelope then drops at once to a lower
//   wanted gain or is smoothed toward it; the shared multiplier takes up
//   to four passes per frame (two for the envelope, one per channel).
//   If the receiver stalls, the finished result holds and the sequencer
//   waits in its last step until the output register frees up.
//   Reset: configuration registers take their defaults, the envelope and the
//   write pointer clear, and a clearing pass writes zeros through all
//   DELAY_DEPTH entries of both delay lines with in_stall held high.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are taken at any edge.
// ============================================================================
`default_nettype none

module lookahead_peak_limiter
    import lpl_pkg::*;
#(
    parameter int DELAY_DEPTH  = 256,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic        [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic        [CFG_W-1:0]        cfg_data,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] left_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] right_sample,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed      [SAMPLE_WIDTH-1:0] left_out,
    output logic signed      [SAMPLE_WIDTH-1:0] right_out,
    output logic             [GAIN_W-1:0]       gain_now
);

    localparam int AW     = $clog2(DELAY_DEPTH);
    localparam int DW     = (AW > DELAY_W) ? AW : DELAY_W;
    localparam int MA_W   = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W;
    localparam int PROD_W = MA_W + GAIN_W;
    localparam int MAG_W  = PROD_W + 1 - FRAC_W;
    localparam int CMP_W  = (SAMPLE_WIDTH > CEIL_W) ? SAMPLE_WIDTH : CEIL_W;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [SAMPLE_WIDTH-1:0] mag_of(input logic [SAMPLE_WIDTH-1:0] v);
        return v[SAMPLE_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    // Round half away from zero, clamp to the ceiling, restore the sign.
    function automatic logic [SAMPLE_WIDTH-1:0] gain_out(
        input logic [PROD_W-1:0] prod,
        input logic              neg,
        input logic [CEIL_W-1:0] ceil_v
    );
        logic [PROD_W:0]         rsum;
        logic [MAG_W-1:0]        rmag;
        logic [SAMPLE_WIDTH-1:0] rs;
        rsum = {1'b0, prod} + (PROD_W + 1)'(1 << (FRAC_W - 1));
        rmag = rsum[PROD_W:FRAC_W];
        if (rmag > MAG_W'(ceil_v))
        begin
            rmag = MAG_W'(ceil_v);
        end
        rs = SAMPLE_WIDTH'(rmag);
        return neg ? (~rs + 1'b1) : rs;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CEIL_W-1:0]  ceiling_reg;
    logic [COEF_W-1:0]  release_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic               stereo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg <= CEILING_RST;
            release_reg <= RELEASE_RST;
            delay_reg   <= DELAY_RST;
            chan_reg    <= CHANNEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CEILING: ceiling_reg <= cfg_data[CEIL_W-1:0];
                CFG_RELEASE: release_reg <= cfg_data[COEF_W-1:0];
                CFG_DELAY:   delay_reg   <= cfg_data[DELAY_W-1:0];
                CFG_CHANNEL: chan_reg    <= cfg_data[CHAN_W-1:0];
                default:     ;
            endcase
        end
    end

    // count of two or three means stereo, zero or one means mono
    assign stereo = chan_reg[1];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    lpl_state_t state_reg, state_next;

    logic [AW-1:0]           wp_reg, wp_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic [GAIN_W-1:0]       env_reg, env_next;
    logic [GAIN_W-1:0]       desired_reg, desired_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [PROD_W-1:0]       prod_reg;
    logic [SAMPLE_WIDTH-1:0] lo_reg, lo_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] left_out_reg, left_out_next;
    logic [SAMPLE_WIDTH-1:0] right_out_reg, right_out_next;
    logic [GAIN_W-1:0]       gain_reg, gain_next;

    // ------------------------------------------------------------------
    // Input side: peak, read address
    // ------------------------------------------------------------------
    logic                    accept;
    logic [SAMPLE_WIDTH-1:0] mag_l, mag_r, peak;
    logic                    over;
    logic [DW-1:0]           delay_ext;
    logic [AW-1:0]           delay_eff;
    logic [AW-1:0]           rd_addr;

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign mag_l  = mag_of(left_sample);
    assign mag_r  = mag_of(right_sample);
    assign peak   = (stereo && (mag_r > mag_l)) ? mag_r : mag_l;
    assign over   = CMP_W'(peak) > CMP_W'(ceiling_reg);

    // clamp the lookahead to 1 .. DELAY_DEPTH-1
    always_comb
    begin
        delay_ext = DW'(delay_reg);
        if (delay_ext == '0)
        begin
            delay_eff = AW'(1);
        end
        else if (delay_ext > DW'(DELAY_DEPTH - 1))
        begin
            delay_eff = AW'(DELAY_DEPTH - 1);
        end
        else
        begin
            delay_eff = AW'(delay_ext);
        end
    end

    always_comb
    begin
        if (wp_reg >= delay_eff)
        begin
            rd_addr = wp_reg - delay_eff;
        end
        else
        begin
            rd_addr = AW'(({1'b0, wp_reg} + (AW + 1)'(DELAY_DEPTH)) - {1'b0, delay_eff});
        end
    end

    // ------------------------------------------------------------------
    // Delay lines
    // ------------------------------------------------------------------
    logic                    clearing;
    logic                    l_we, r_we;
    logic [AW-1:0]           waddr;
    logic [SAMPLE_WIDTH-1:0] l_wdata, r_wdata;
    logic [SAMPLE_WIDTH-1:0] dl, dr;

    assign clearing = (state_reg == ST_CLEAR);
    assign l_we     = clearing || accept;
    assign r_we     = clearing || (accept && stereo);
    assign waddr    = clearing ? clr_reg : wp_reg;
    assign l_wdata  = clearing ? '0 : left_sample;
    assign r_wdata  = clearing ? '0 : right_sample;

    lpl_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (DELAY_DEPTH)
    ) u_left_line (
        .clk   (clk),
        .we    (l_we),
        .waddr (waddr),
        .wdata (l_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (dl)
    );

    lpl_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (DELAY_DEPTH)
    ) u_right_line (
        .clk   (clk),
        .we    (r_we),
        .waddr (waddr),
        .wdata (r_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (dr)
    );

    // ------------------------------------------------------------------
    // Gain divider
    // ------------------------------------------------------------------
    logic              div_start;
    logic              div_done;
    logic [FRAC_W-1:0] div_q;

    assign div_start = accept && over;

    lpl_div #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .ceiling  (ceiling_reg),
        .peak     (peak),
        .done     (div_done),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // Shared multiplier: operands chosen by the sequencer step
    // ------------------------------------------------------------------
    logic [MA_W-1:0]   mul_a;
    logic [GAIN_W-1:0] mul_b;
    logic              mul_en;
    logic [GAIN_W-1:0] one_minus_c;

    assign one_minus_c = UNITY_GAIN - {1'b0, release_reg};

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        case (state_reg)
            ST_MUL_CE:
            begin
                mul_a  = MA_W'(release_reg);
                mul_b  = env_reg;
                mul_en = 1'b1;
            end
            ST_MUL_CD:
            begin
                mul_a  = MA_W'(one_minus_c);
                mul_b  = desired_reg;
                mul_en = 1'b1;
            end
            ST_MUL_L:
            begin
                mul_a  = MA_W'(mag_of(dl));
                mul_b  = env_reg;
                mul_en = 1'b1;
            end
            ST_MUL_R:
            begin
                mul_a  = MA_W'(mag_of(dr));
                mul_b  = env_reg;
                mul_en = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [ACC_W:0]  env_sum;
    logic [GAIN_W:0] env_q;
    logic            out_free;

    assign env_sum  = {1'b0, acc_reg} + (ACC_W + 1)'((1 << FRAC_W) - 1);
    assign env_q    = env_sum[ACC_W:FRAC_W];
    assign out_free = !(out_valid_reg && out_stall);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        clr_next       = clr_reg;
        env_next       = env_reg;
        desired_next   = desired_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        gain_next      = gain_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep zeros through both delay lines
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DELAY_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    wp_next = (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    if (over)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        desired_next = UNITY_GAIN;
                        state_next   = ST_MUL_CE;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    desired_next = {1'b0, div_q};
                    state_next   = ST_MUL_CE;
                end
            end
            ST_MUL_CE:
            begin
                // attack: drop at once to a lower wanted gain
                if (desired_reg < env_reg)
                begin
                    env_next   = desired_reg;
                    state_next = ST_MUL_L;
                end
                else
                begin
                    state_next = ST_MUL_CD;
                end
            end
            ST_MUL_CD:
            begin
                acc_next   = ACC_W'(prod_reg);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = ST_ENV;
            end
            ST_ENV:
            begin
                // release: round up, never pass unity
                if (env_q > (GAIN_W + 1)'(UNITY_GAIN))
                begin
                    env_next = UNITY_GAIN;
                end
                else
                begin
                    env_next = env_q[GAIN_W-1:0];
                end
                state_next = ST_MUL_L;
            end
            ST_MUL_L:
            begin
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                lo_next    = gain_out(prod_reg, dl[SAMPLE_WIDTH-1], ceiling_reg);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold here while the previous item still waits
                if (out_free)
                begin
                    left_out_next  = lo_reg;
                    right_out_next = stereo ?
                                     gain_out(prod_reg, dr[SAMPLE_WIDTH-1], ceiling_reg) : '0;
                    gain_next      = env_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            wp_reg        <= '0;
            clr_reg       <= '0;
            env_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            clr_reg       <= clr_next;
            env_reg       <= env_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desired_reg   <= desired_next;
        acc_reg       <= acc_next;
        lo_reg        <= lo_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        gain_reg      <= gain_next;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign gain_now  = gain_reg;

endmodule

`default_nettype wire

### rtl/lpl_checker.sv
// ============================================================================
// lpl_checker - port-level assertions for the lookahead peak limiter
// Watches the channels of the top level and is bound to it below.
// ============================================================================
`default_nettype none

module lpl_checker
    import lpl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_stall,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire logic [SAMPLE_WIDTH-1:0] left_out,
    input wire logic [SAMPLE_WIDTH-1:0] right_out,
    input wire logic [GAIN_W-1:0]       gain_now
);

    // one frame at a time: busy right after an accept
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input taken while a frame is in progress");

    // a result never appears the cycle after its frame is taken
    a_no_instant_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid) |=> !out_valid
    ) else $error("result appeared too early");

    // envelope never exceeds unity
    a_gain_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (gain_now <= UNITY_GAIN)
    ) else $error("gain above unity");

    // zero gain silences both channels
    a_zero_gain_silent: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (gain_now == '0)) |-> ((left_out == '0) && (right_out == '0))
    ) else $error("nonzero output at zero gain");

    // stalled result holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(left_out) && $stable(right_out) && $stable(gain_now))
    ) else $error("stalled result changed");

endmodule

bind lookahead_peak_limiter lpl_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lpl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_out  (left_out),
    .right_out (right_out),
    .gain_now  (gain_now)
);

`default_nettype wire
